// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define APT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define APT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/apt_pkg.sv =====
// Package for the aging peer table: sizes, codes and payload types
`default_nettype none

package apt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ID_BITS     = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W     = 32;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int PADDR_W     = 3;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd60000;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_PRUNE  = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OUT_NONE      = 3'd0,
        OUT_IGNORED   = 3'd1,
        OUT_REFRESHED = 3'd2,
        OUT_APPENDED  = 3'd3,
        OUT_REPLACED  = 3'd4
    } outcome_t;

    typedef enum logic [0:0] {
        REG_OWN_ID = 1'b0,
        REG_TTL_MS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] peer_id;
        logic [TIME_W-1:0]  now_ms;
    } in_t;

    typedef struct packed {
        logic               found;
        outcome_t           outcome;
        logic [COUNT_W-1:0] removed;
        logic [COUNT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [TIME_W-1:0]  seen;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/apt_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none

module apt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/aging_peer_table.sv =====
// Aging peer table: bounded id table with last-seen times, prune by age, oldest replacement
// Each item scans the stored entries one at a time, N = entries held (0..16), then finishes;
// a clear, or an item on an empty table, goes straight to the finish state. Each stored entry
// passes through a RAM read state and a compare state on the one shared unit.
// Ready only while idle: a new item is taken only after the finish state hands off the last result.
// Reset: count cleared, own_id 0, ttl_ms 60000, no result pending; RAM contents not reset.
`default_nettype none

module aging_peer_table
    import apt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_t                    out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    state_t             state_reg, state_next;
    logic [ID_BITS-1:0] own_id_reg, own_id_next;
    logic [TIME_W-1:0]  ttl_reg, ttl_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    kind_t              kind_reg, kind_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [TIME_W-1:0]  min_seen_reg, min_seen_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             rd_entry;

    logic               cfg_write;
    reg_idx_t           cfg_sel;
    logic               out_free;
    logic [TIME_W-1:0]  seen_val;
    logic [TIME_W-1:0]  age;
    logic               keep;
    logic               ignore;

    apt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_entry)
    );

    assign cfg_sel   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (cfg_sel == REG_TTL_MS) ? ttl_reg : FIELD_W'(own_id_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign seen_val  = (now_reg == '0) ? TIME_W'(1) : now_reg;
    assign age       = now_reg - rd_entry.seen;
    assign keep      = (age <= ttl_reg);
    assign ignore    = (key_reg == '0) || (key_reg == own_id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            own_id_reg    <= '0;
            ttl_reg       <= TTL_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            own_id_reg    <= own_id_next;
            ttl_reg       <= ttl_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        wr_ptr_reg   <= wr_ptr_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        min_idx_reg  <= min_idx_next;
        min_seen_reg <= min_seen_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        own_id_next    = own_id_reg;
        ttl_next       = ttl_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        wr_ptr_next    = wr_ptr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        min_idx_next   = min_idx_reg;
        min_seen_next  = min_seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = rd_entry;
        ram_raddr      = idx_reg[IDX_W-1:0];

        if (cfg_write)
        begin
            case (cfg_sel)
                REG_OWN_ID: own_id_next = ID_BITS'(pwdata);
                REG_TTL_MS: ttl_next    = pwdata;
                default:    ttl_next    = ttl_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = in_data.kind;
                    key_next      = ID_BITS'(in_data.peer_id);
                    now_next      = in_data.now_ms;
                    idx_next      = '0;
                    wr_ptr_next   = '0;
                    hit_next      = 1'b0;
                    hit_idx_next  = '0;
                    min_idx_next  = '0;
                    min_seen_next = '0;
                    if (count_reg == '0 || in_data.kind == KIND_CLEAR)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (kind_reg == KIND_PRUNE)
                begin
                    if (keep)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_ptr_reg[IDX_W-1:0];
                        ram_wdata   = rd_entry;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (!hit_reg && rd_entry.id == key_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_reg[IDX_W-1:0];
                    end
                    if (idx_reg == '0 || rd_entry.seen < min_seen_reg)
                    begin
                        min_idx_next  = idx_reg[IDX_W-1:0];
                        min_seen_next = rd_entry.seen;
                    end
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_data_next.found   = 1'b0;
                    out_data_next.outcome = OUT_NONE;
                    out_data_next.removed = '0;
                    case (kind_reg)
                        KIND_RECORD:
                        begin
                            ram_wdata.id   = key_reg;
                            ram_wdata.seen = seen_val;
                            if (ignore)
                            begin
                                out_data_next.outcome = OUT_IGNORED;
                            end
                            else if (hit_reg)
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = hit_idx_reg;
                                out_data_next.outcome = OUT_REFRESHED;
                            end
                            else if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = count_reg[IDX_W-1:0];
                                count_next            = count_reg + CNT_W'(1);
                                out_data_next.outcome = OUT_APPENDED;
                            end
                            else
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = min_idx_reg;
                                out_data_next.outcome = OUT_REPLACED;
                            end
                        end
                        KIND_PRUNE:
                        begin
                            out_data_next.removed = COUNT_W'(count_reg - wr_ptr_reg);
                            count_next            = wr_ptr_reg;
                        end
                        KIND_QUERY:
                        begin
                            out_data_next.found = hit_reg && (key_reg != '0);
                        end
                        KIND_CLEAR:
                        begin
                            out_data_next.removed = COUNT_W'(count_reg);
                            count_next            = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    out_data_next.entry_count = COUNT_W'(count_next);
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/apt_checker.sv =====
// Port-level checker for the aging peer table, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module apt_checker
    import apt_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    `APT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed before transfer")
    `APT_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "ready while an item is at work")
    `APT_ASSERT(a_count_range, out_valid |-> out_data.entry_count <= COUNT_W'(TABLE_DEPTH), "entry count above table depth")
    `APT_ASSERT(a_removed_range, out_valid |-> ({1'b0, out_data.removed} + {1'b0, out_data.entry_count}) <= (COUNT_W + 1)'(TABLE_DEPTH), "removed plus count above table depth")
    `APT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind aging_peer_table apt_checker u_apt_checker (.*);

`default_nettype wire
